/* rtl/oscpm_pkg.sv */
// Shared types and character codes for the address pattern matcher.
package oscpm_pkg;

	localparam int PAT_DEPTH_DEF = 64;
	localparam int ADR_DEPTH_DEF = 64;

	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_QMARK  = 8'h3f;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic {
		OP_PATTERN = 1'b0,
		OP_ADDRESS = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CLS_INVALID = 2'd0,
		CLS_STATIC  = 2'd1,
		CLS_DYNAMIC = 2'd2
	} cls_t;

	// One job handed from the front to the back
	typedef struct packed {
		op_t  kind;
		cls_t verdict;
		cls_t pclass;
		logic aovf;
	} job_t;

endpackage

/* rtl/oscpm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module oscpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/oscpm_queue.sv */
// Two-entry job queue between the front and the back.
module oscpm_queue import oscpm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic valid,
	output job_t head
);

	job_t       slot_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = slot_q[rd_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_job;
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) full |-> !push || pop;
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

	property p_no_underflow;
		@(posedge clk) disable iff (!arst_n) pop |-> valid;
	endproperty
	a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

	property p_count_range;
		@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3;
	endproperty
	a_count_range: assert property (p_count_range) else $error("queue count out of range");

endmodule

/* rtl/oscpm_front.sv */
// Front: accepts bytes, fills the stores, verifies patterns on the fly, issues jobs.
module oscpm_front import oscpm_pkg::*; #(
	parameter int PATTERN_DEPTH = PAT_DEPTH_DEF,
	parameter int ADDRESS_DEPTH = ADR_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,
	input  logic                               s_axis_tuser,
	input  logic                               s_axis_tlast,
	output logic                               pat_we,
	output logic [$clog2(PATTERN_DEPTH)-1:0]   pat_waddr,
	output logic                               adr_we,
	output logic [$clog2(ADDRESS_DEPTH)-1:0]   adr_waddr,
	output logic [7:0]                         wdata,
	output logic [$clog2(PATTERN_DEPTH+1)-1:0] plen,
	output logic [$clog2(ADDRESS_DEPTH+1)-1:0] alen,
	output logic                               push,
	output job_t                               push_job,
	input  logic                               q_full,
	input  logic                               match_done
);

	localparam int PW = $clog2(PATTERN_DEPTH+1);
	localparam int AW = $clog2(ADDRESS_DEPTH+1);
	localparam int PA = $clog2(PATTERN_DEPTH);
	localparam int AA = $clog2(ADDRESS_DEPTH);

	logic [PW-1:0] plen_q;
	logic [AW-1:0] alen_q;
	logic          pdone_q, povf_q, adone_q, aovf_q, busy_q;
	cls_t          pclass_q;
	// Running verifier state
	logic          bad_q, pslash_q, inbr_q, segnz_q, meta_q;

	logic          acc, is_pat, is_adr;
	logic [PW-1:0] ple;
	logic [AW-1:0] ale;
	logic          pfit, afit, povf_n, aovf_n;
	logic          bad_d, pslash_d, inbr_d, segnz_d, meta_d, lslash_d;
	cls_t          cls_n;
	logic [7:0]    ch;

	assign ch            = s_axis_tdata;
	assign s_axis_tready = !busy_q && !q_full;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign is_pat        = acc && (op_t'(s_axis_tuser) == OP_PATTERN);
	assign is_adr        = acc && (op_t'(s_axis_tuser) == OP_ADDRESS);

	// Restart a string after its last byte
	assign ple    = pdone_q ? '0 : plen_q;
	assign ale    = adone_q ? '0 : alen_q;
	assign pfit   = (ple < PW'(PATTERN_DEPTH));
	assign afit   = (ale < AW'(ADDRESS_DEPTH));
	assign povf_n = (pdone_q ? 1'b0 : povf_q) || !pfit;
	assign aovf_n = (adone_q ? 1'b0 : aovf_q) || !afit;

	assign pat_we    = is_pat && pfit;
	assign pat_waddr = ple[PA-1:0];
	assign adr_we    = is_adr && afit;
	assign adr_waddr = ale[AA-1:0];
	assign wdata     = ch;
	assign plen      = plen_q;
	assign alen      = alen_q;

	// Verify one pattern character
	always_comb begin
		bad_d    = bad_q;
		pslash_d = pslash_q;
		inbr_d   = inbr_q;
		segnz_d  = segnz_q;
		meta_d   = meta_q;
		lslash_d = (ch == CH_SLASH);
		if (ple == '0) begin
			bad_d    = (ch != CH_SLASH);
			pslash_d = 1'b1;
			inbr_d   = 1'b0;
			segnz_d  = 1'b0;
			meta_d   = 1'b0;
		end else if (inbr_q) begin
			pslash_d = 1'b0;
			case (ch) inside
				CH_SLASH, CH_HASH, CH_RBRACK, CH_SPACE, CH_STAR, CH_QMARK: bad_d = 1'b1;
				CH_COMMA: begin
					if (!segnz_q) bad_d = 1'b1;
					segnz_d = 1'b0;
				end
				CH_RBRACE: begin
					if (!segnz_q) bad_d = 1'b1;
					inbr_d = 1'b0;
				end
				default: segnz_d = 1'b1;
			endcase
		end else begin
			pslash_d = 1'b0;
			case (ch) inside
				CH_SLASH: begin
					if (pslash_q) bad_d = 1'b1;
					pslash_d = 1'b1;
				end
				CH_LBRACE: begin
					meta_d  = 1'b1;
					inbr_d  = 1'b1;
					segnz_d = 1'b0;
				end
				CH_STAR, CH_QMARK: meta_d = 1'b1;
				CH_LBRACK, CH_HASH, CH_RBRACK, CH_RBRACE, CH_COMMA, CH_SPACE: bad_d = 1'b1;
				default: ;
			endcase
		end
		if (povf_n || bad_d || inbr_d || lslash_d) cls_n = CLS_INVALID;
		else if (meta_d) cls_n = CLS_DYNAMIC;
		else cls_n = CLS_STATIC;
	end

	// Issue a job on each last byte
	always_comb begin
		push             = acc && s_axis_tlast;
		push_job.kind    = op_t'(s_axis_tuser);
		push_job.verdict = cls_n;
		push_job.pclass  = pclass_q;
		push_job.aovf    = aovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= '0;
			alen_q   <= '0;
			pdone_q  <= 1'b0;
			povf_q   <= 1'b0;
			adone_q  <= 1'b0;
			aovf_q   <= 1'b0;
			busy_q   <= 1'b0;
			pclass_q <= CLS_INVALID;
			bad_q    <= 1'b0;
			pslash_q <= 1'b0;
			inbr_q   <= 1'b0;
			segnz_q  <= 1'b0;
			meta_q   <= 1'b0;
		end else begin
			if (match_done) busy_q <= 1'b0;
			if (is_pat) begin
				povf_q   <= povf_n;
				pdone_q  <= s_axis_tlast;
				pclass_q <= s_axis_tlast ? cls_n : CLS_INVALID;
				plen_q   <= pfit ? ple + PW'(1) : ple;
				if (pfit) begin
					bad_q    <= bad_d;
					pslash_q <= pslash_d;
					inbr_q   <= inbr_d;
					segnz_q  <= segnz_d;
					meta_q   <= meta_d;
				end
			end
			if (is_adr) begin
				aovf_q  <= aovf_n;
				adone_q <= s_axis_tlast;
				alen_q  <= afit ? ale + AW'(1) : ale;
				if (s_axis_tlast) busy_q <= 1'b1;
			end
		end
	end

	property p_stall_busy;
		@(posedge clk) disable iff (!arst_n) busy_q |-> !s_axis_tready;
	endproperty
	a_stall_busy: assert property (p_stall_busy) else $error("byte taken during match");

	property p_len_bound;
		@(posedge clk) disable iff (!arst_n)
			plen_q <= PW'(PATTERN_DEPTH) && alen_q <= AW'(ADDRESS_DEPTH);
	endproperty
	a_len_bound: assert property (p_len_bound) else $error("length beyond depth");

	property p_busy_set;
		@(posedge clk) disable iff (!arst_n) is_adr && s_axis_tlast |=> busy_q;
	endproperty
	a_busy_set: assert property (p_busy_set) else $error("match not marked busy");

endmodule

/* rtl/oscpm_back.sv */
// Back: runs verify results out and walks the stores for an address match.
module oscpm_back import oscpm_pkg::*; #(
	parameter int PATTERN_DEPTH = PAT_DEPTH_DEF,
	parameter int ADDRESS_DEPTH = ADR_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               job_valid,
	input  job_t                               job,
	output logic                               pop,
	input  logic [$clog2(PATTERN_DEPTH+1)-1:0] plen,
	input  logic [$clog2(ADDRESS_DEPTH+1)-1:0] alen,
	output logic [$clog2(PATTERN_DEPTH)-1:0]   pat_raddr,
	input  logic [7:0]                         pat_rdata,
	output logic [$clog2(ADDRESS_DEPTH)-1:0]   adr_raddr,
	input  logic [7:0]                         adr_rdata,
	output logic                               match_done,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [7:0]                         m_axis_tdata,
	output logic                               m_axis_tuser
);

	localparam int PW = $clog2(PATTERN_DEPTH+1);
	localparam int AW = $clog2(ADDRESS_DEPTH+1);
	localparam int PA = $clog2(PATTERN_DEPTH);
	localparam int AA = $clog2(ADDRESS_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_STATIC, ST_MAIN, ST_SLASH, ST_STAR, ST_BRACE,
		ST_BRPOST, ST_SKIPW, ST_SKIPEND, ST_END, ST_ENDB, ST_RESULT
	} state_t;

	state_t        state_q, state_d;
	logic [PW-1:0] p_q, p_d;
	logic [AW-1:0] i_q, i_d, slash_q, slash_d, mark_q, mark_d;
	logic          res_q, res_d;
	logic          ovalid_q;
	op_t           okind_q;
	cls_t          overd_q;
	logic          out_free, out_load;
	op_t           out_kind;
	cls_t          out_verd;
	logic          pv, av;
	logic [7:0]    c, a;

	assign out_free = !ovalid_q || m_axis_tready;
	assign pv = (p_q < plen);
	assign av = (i_q < alen);
	assign c  = pat_rdata;
	assign a  = adr_rdata;

	// Read the stores at the next walk position
	assign pat_raddr = p_d[PA-1:0];
	assign adr_raddr = i_d[AA-1:0];

	// Step the match walk
	always_comb begin
		state_d    = state_q;
		p_d        = p_q;
		i_d        = i_q;
		slash_d    = slash_q;
		mark_d     = mark_q;
		res_d      = res_q;
		pop        = 1'b0;
		out_load   = 1'b0;
		out_kind   = OP_ADDRESS;
		out_verd   = CLS_INVALID;
		match_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (job_valid && out_free) begin
					pop     = 1'b1;
					p_d     = '0;
					i_d     = '0;
					slash_d = '0;
					res_d   = 1'b0;
					if (job.kind == OP_PATTERN) begin
						out_load = 1'b1;
						out_kind = OP_PATTERN;
						out_verd = job.verdict;
					end else if (job.aovf) begin
						state_d = ST_RESULT;
					end else if (job.pclass == CLS_STATIC) begin
						state_d = (32'(alen) == 32'(plen)) ? ST_STATIC : ST_RESULT;
					end else if (job.pclass == CLS_DYNAMIC) begin
						state_d = ST_INIT;
					end else begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_INIT: begin
				if (!av || a != CH_SLASH) begin
					state_d = ST_RESULT;
				end else begin
					p_d     = PW'(1);
					i_d     = AW'(1);
					state_d = ST_MAIN;
				end
			end
			ST_STATIC: begin
				if (!pv) begin
					res_d   = 1'b1;
					state_d = ST_RESULT;
				end else if (c != a) begin
					state_d = ST_RESULT;
				end else begin
					p_d = p_q + PW'(1);
					i_d = i_q + AW'(1);
				end
			end
			ST_MAIN: begin
				if (!(pv && av)) begin
					state_d = ST_END;
				end else if (a == CH_SLASH) begin
					slash_d = i_q;
					if (i_q == slash_q + AW'(1)) begin
						state_d = ST_RESULT;
					end else if (c == CH_STAR) begin
						p_d     = p_q + PW'(1);
						state_d = ST_SLASH;
					end else if (c != CH_SLASH) begin
						state_d = ST_RESULT;
					end else begin
						p_d = p_q + PW'(1);
						i_d = i_q + AW'(1);
					end
				end else begin
					case (c) inside
						CH_QMARK: begin
							p_d = p_q + PW'(1);
							i_d = i_q + AW'(1);
						end
						CH_STAR: state_d = ST_STAR;
						CH_LBRACK: state_d = ST_RESULT;
						CH_LBRACE: begin
							mark_d  = i_q;
							p_d     = p_q + PW'(1);
							state_d = ST_BRACE;
						end
						default: begin
							if (c != a) begin
								state_d = ST_RESULT;
							end else begin
								p_d = p_q + PW'(1);
								i_d = i_q + AW'(1);
							end
						end
					endcase
				end
			end
			ST_SLASH: begin
				if (!(pv && c == CH_SLASH)) begin
					state_d = ST_RESULT;
				end else begin
					p_d     = p_q + PW'(1);
					i_d     = i_q + AW'(1);
					state_d = ST_MAIN;
				end
			end
			ST_STAR: begin
				if (av && a != CH_SLASH) begin
					i_d = i_q + AW'(1);
				end else begin
					p_d     = p_q + PW'(1);
					state_d = ST_MAIN;
				end
			end
			ST_BRACE: begin
				if (!pv) begin
					state_d = ST_RESULT;
				end else if (av && c == a) begin
					p_d     = p_q + PW'(1);
					i_d     = i_q + AW'(1);
					state_d = ST_BRPOST;
				end else begin
					i_d     = mark_q;
					state_d = ST_SKIPW;
				end
			end
			ST_BRPOST: begin
				if (pv && c == CH_COMMA) begin
					state_d = ST_SKIPEND;
				end else if (pv && c == CH_RBRACE) begin
					p_d     = p_q + PW'(1);
					state_d = ST_MAIN;
				end else begin
					state_d = ST_BRACE;
				end
			end
			ST_SKIPW: begin
				if (pv && c != CH_COMMA && c != CH_RBRACE) begin
					p_d = p_q + PW'(1);
				end else if (!(pv && c == CH_COMMA)) begin
					state_d = ST_RESULT;
				end else begin
					p_d     = p_q + PW'(1);
					state_d = ST_BRACE;
				end
			end
			ST_SKIPEND: begin
				if (pv && c != CH_RBRACE) begin
					p_d = p_q + PW'(1);
				end else if (!pv) begin
					state_d = ST_RESULT;
				end else begin
					p_d     = p_q + PW'(1);
					state_d = ST_MAIN;
				end
			end
			ST_END: begin
				if (pv && c == CH_STAR) begin
					p_d     = p_q + PW'(1);
					state_d = ST_ENDB;
				end else begin
					res_d   = !pv && !av;
					state_d = ST_RESULT;
				end
			end
			ST_ENDB: begin
				res_d   = !pv && !av;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_kind   = OP_ADDRESS;
					out_verd   = res_q ? CLS_STATIC : CLS_INVALID;
					match_done = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			p_q      <= '0;
			i_q      <= '0;
			slash_q  <= '0;
			mark_q   <= '0;
			res_q    <= 1'b0;
			ovalid_q <= 1'b0;
			okind_q  <= OP_PATTERN;
			overd_q  <= CLS_INVALID;
		end else begin
			state_q <= state_d;
			p_q     <= p_d;
			i_q     <= i_d;
			slash_q <= slash_d;
			mark_q  <= mark_d;
			res_q   <= res_d;
			if (out_load) begin
				ovalid_q <= 1'b1;
				okind_q  <= out_kind;
				overd_q  <= out_verd;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {6'd0, overd_q};
	assign m_axis_tuser  = okind_q;

	property p_walk_bound;
		@(posedge clk) disable iff (!arst_n)
			state_q != ST_IDLE |-> p_q <= plen && i_q <= alen;
	endproperty
	a_walk_bound: assert property (p_walk_bound) else $error("walk past stored length");

	property p_done_from_result;
		@(posedge clk) disable iff (!arst_n) match_done |-> state_q == ST_RESULT && out_load;
	endproperty
	a_done_from_result: assert property (p_done_from_result) else $error("stray match done");

	property p_match_verdict;
		@(posedge clk) disable iff (!arst_n)
			ovalid_q && okind_q == OP_ADDRESS |-> overd_q != CLS_DYNAMIC;
	endproperty
	a_match_verdict: assert property (p_match_verdict) else $error("bad match verdict");

endmodule

/* rtl/osc_address_pattern_matcher_top.sv */
// Top level of the address pattern matcher: front, job queue, back and the two stores.
// Bytes are taken back to back while no match runs and the job queue has room; a pattern's verdict
// passes through the job queue and the back's output register. A match walks the stores one step per
// cycle (both read ports); each matched character of a brace word passes through the ST_BRACE
// and ST_BRPOST states.
// While a match is in progress no byte is taken.
// Reset (arst_n low) clears lengths, flags, pattern class and the queue; store contents are kept.
module osc_address_pattern_matcher_top import oscpm_pkg::*; #(
	parameter int PATTERN_DEPTH = PAT_DEPTH_DEF,
	parameter int ADDRESS_DEPTH = ADR_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] char_byte
	input  logic       s_axis_tuser,  // [0] op
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [1:0] verdict, [7:2] zero
	output logic       m_axis_tuser   // [0] kind
);

	localparam int PW = $clog2(PATTERN_DEPTH+1);
	localparam int AW = $clog2(ADDRESS_DEPTH+1);
	localparam int PA = $clog2(PATTERN_DEPTH);
	localparam int AA = $clog2(ADDRESS_DEPTH);

	logic          pat_we, adr_we;
	logic [PA-1:0] pat_waddr, pat_raddr;
	logic [AA-1:0] adr_waddr, adr_raddr;
	logic [7:0]    wdata, pat_rdata, adr_rdata;
	logic [PW-1:0] plen;
	logic [AW-1:0] alen;
	logic          push, q_full, pop, job_valid, match_done;
	job_t          push_job, head;

	oscpm_front #(.PATTERN_DEPTH(PATTERN_DEPTH), .ADDRESS_DEPTH(ADDRESS_DEPTH)) u_front (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
		.pat_we, .pat_waddr, .adr_we, .adr_waddr, .wdata,
		.plen, .alen, .push, .push_job, .q_full, .match_done
	);

	oscpm_queue u_queue (
		.clk, .arst_n, .push, .push_job, .full(q_full), .pop, .valid(job_valid), .head
	);

	oscpm_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
		.clk, .we(pat_we), .waddr(pat_waddr), .wdata, .raddr(pat_raddr), .rdata(pat_rdata)
	);

	oscpm_ram #(.WIDTH(8), .DEPTH(ADDRESS_DEPTH)) u_adr_ram (
		.clk, .we(adr_we), .waddr(adr_waddr), .wdata, .raddr(adr_raddr), .rdata(adr_rdata)
	);

	oscpm_back #(.PATTERN_DEPTH(PATTERN_DEPTH), .ADDRESS_DEPTH(ADDRESS_DEPTH)) u_back (
		.clk, .arst_n, .job_valid, .job(head), .pop, .plen, .alen,
		.pat_raddr, .pat_rdata, .adr_raddr, .adr_rdata, .match_done,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
	);

endmodule
